@@ rtl/rpid_pkg.sv @@
// ----------------------------------------------------------------------------
// Roll PID regulator package
// Beat types, register indexes, sequencer states and fixed constants.
// ----------------------------------------------------------------------------
package rpid_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN_DT = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN_DT = 2'd2;
  localparam logic [1:0] REG_ELEVATOR_HOLD = 2'd3;

  // pi/180 in Q.22, rounded.
  localparam logic signed [17:0] DEG2RAD = 18'sd73204;
  // 1.0 in Q1.14.
  localparam int CMD_ONE = 16384;

  localparam logic signed [15:0] PROP_GAIN_RST     = 16'sd5120;
  localparam logic signed [15:0] ELEVATOR_HOLD_RST = -16'sd4096;

  typedef struct packed {
    logic signed [15:0] target_deg;
    logic signed [15:0] roll_meas;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] aileron_cmd;
    logic signed [15:0] elevator_cmd;
    logic               clamped;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SUM,
    S_PROP,
    S_DERIV,
    S_ILO,
    S_IHI,
    S_OUT
  } state_t;

endpackage

@@ rtl/roll_pid_regulator_unit.sv @@
// ----------------------------------------------------------------------------
// Roll PID regulator unit
// One item is in flight at a time: no new input beat is taken until the
// result register has been written, which waits while the output side stalls.
// A single 18 x MB signed multiplier is reused for the degree conversion and
// all four gain products.
// Reset (synchronous) restores the default gains and clears the error sum,
// the previous error and the output valid flag.
// ----------------------------------------------------------------------------
module roll_pid_regulator_unit #(
  parameter int SUM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpid_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpid_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import rpid_pkg::*;

  // The error sum is multiplied in two halves: an unsigned low part and a
  // signed high part that is shifted back into place when accumulated.
  localparam int LO_W  = SUM_WIDTH / 2;
  localparam int HI_W  = SUM_WIDTH - LO_W;
  localparam int MB    = (HI_W + 1 > 18) ? HI_W + 1 : 18;
  localparam int PW    = 18 + MB;
  localparam int ACC_W = SUM_WIDTH + 18;
  localparam int CMD_W = ACC_W - 6;
  localparam logic signed [CMD_W-1:0] CMD_HI = CMD_W'(CMD_ONE);
  localparam logic signed [CMD_W-1:0] CMD_LO = -CMD_W'(CMD_ONE);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  state_t state, state_next;

  logic signed [15:0] prop_gain, integ_gain_dt, deriv_gain_per_dt, elevator_hold;
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [15:0] last_error;
  logic signed [15:0] roll_r;
  logic signed [15:0] err;
  logic signed [16:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [17:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  logic signed [PW-1:0] conv_rnd;
  logic signed [17:0] rad;
  logic signed [18:0] err_wide;
  logic signed [15:0] err_sat;
  logic signed [SUM_WIDTH:0] sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] rnd;
  logic signed [CMD_W-1:0] cmd_w;
  logic signed [15:0] cmd_q;
  logic cmd_clamped;
  logic out_free;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ERR;
      S_ERR:   state_next = S_SUM;
      S_SUM:   state_next = S_PROP;
      S_PROP:  state_next = S_DERIV;
      S_DERIV: state_next = S_ILO;
      S_ILO:   state_next = S_IHI;
      S_IHI:   state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs, mainly the operand select of the shared multiplier.
  always_comb begin
    in_ready = 1'b0;
    mul_a    = DEG2RAD;
    mul_b    = {{(MB-16){in_data.target_deg[15]}}, in_data.target_deg};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_SUM: begin
        mul_a = {{2{prop_gain[15]}}, prop_gain};
        mul_b = {{(MB-16){err[15]}}, err};
      end
      S_PROP: begin
        mul_a = {{2{deriv_gain_per_dt[15]}}, deriv_gain_per_dt};
        mul_b = {{(MB-17){diff[16]}}, diff};
      end
      S_DERIV: begin
        mul_a = {{2{integ_gain_dt[15]}}, integ_gain_dt};
        mul_b = {{(MB-LO_W){1'b0}}, error_sum[LO_W-1:0]};
      end
      S_ILO: begin
        mul_a = {{2{integ_gain_dt[15]}}, integ_gain_dt};
        mul_b = {{(MB-HI_W){error_sum[SUM_WIDTH-1]}}, error_sum[SUM_WIDTH-1:LO_W]};
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Target in radians, rounded to nearest, then the saturated error.
  assign conv_rnd = prod + PW'(32768);
  assign rad      = conv_rnd[33:16];
  assign err_wide = {rad[17], rad} - {{3{roll_r[15]}}, roll_r};
  always_comb begin
    if (err_wide > 19'sd32767) begin
      err_sat = 16'sh7FFF;
    end else if (err_wide < -19'sd32768) begin
      err_sat = 16'sh8000;
    end else begin
      err_sat = err_wide[15:0];
    end
  end

  // Saturating running sum; overflow shows as disagreeing top bits.
  assign sum_wide = {error_sum[SUM_WIDTH-1], error_sum} + {{(SUM_WIDTH-15){err[15]}}, err};
  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  assign prod_ext = {{(ACC_W-PW){prod[PW-1]}}, prod};

  // Round Q.20 to Q1.14 and clamp to plus or minus one.
  assign rnd   = acc + ACC_W'(32);
  assign cmd_w = rnd[ACC_W-1:6];
  always_comb begin
    cmd_clamped = 1'b0;
    cmd_q       = cmd_w[15:0];
    if (cmd_w > CMD_HI) begin
      cmd_q       = 16'(CMD_ONE);
      cmd_clamped = 1'b1;
    end else if (cmd_w < CMD_LO) begin
      cmd_q       = -16'(CMD_ONE);
      cmd_clamped = 1'b1;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      prop_gain         <= PROP_GAIN_RST;
      integ_gain_dt     <= '0;
      deriv_gain_per_dt <= '0;
      elevator_hold     <= ELEVATOR_HOLD_RST;
      error_sum         <= '0;
      last_error        <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP_GAIN:     prop_gain         <= cfg_data;
          REG_INTEG_GAIN_DT: integ_gain_dt     <= cfg_data;
          REG_DERIV_GAIN_DT: deriv_gain_per_dt <= cfg_data;
          REG_ELEVATOR_HOLD: elevator_hold     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == S_SUM) begin
        error_sum  <= sum_sat;
        last_error <= err;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        roll_r <= in_data.roll_meas;
        prod   <= mul_p;
      end
      S_ERR: begin
        err <= err_sat;
      end
      S_SUM: begin
        diff <= {err[15], err} - {last_error[15], last_error};
        prod <= mul_p;
      end
      S_PROP: begin
        acc  <= prod_ext;
        prod <= mul_p;
      end
      S_DERIV, S_ILO: begin
        acc  <= acc + prod_ext;
        prod <= mul_p;
      end
      S_IHI: begin
        acc <= acc + (prod_ext <<< LO_W);
      end
      S_OUT: begin
        if (out_free) begin
          out_data.aileron_cmd  <= cmd_q;
          out_data.elevator_cmd <= elevator_hold;
          out_data.clamped      <= cmd_clamped;
        end
      end
      default: begin
      end
    endcase
  end

  // A clamped command sits exactly on one of the two limits.
  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamped |->
      out_data.aileron_cmd == 16'(CMD_ONE) || out_data.aileron_cmd == -16'(CMD_ONE))
    else $error("clamped result is not at a limit");

  // A result only ever comes out of the final sequencer step.
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output step");

  // Once a beat is taken, no further beat is taken until the item is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule
